// ===== sv/prime_field_primitive_root_test_top_assert.svh =====
// Assertion macros for the primitive root test block.
`ifndef PRIME_FIELD_PRIMITIVE_ROOT_TEST_TOP_ASSERT_SVH
`define PRIME_FIELD_PRIMITIVE_ROOT_TEST_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PFR_ASSERT_IMPL(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define PFR_ASSERT_NEXT(label, clk, rst, cond, nxt) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) else $error("%m");
`else
`define PFR_ASSERT_IMPL(label, clk, rst, prop)
`define PFR_ASSERT_NEXT(label, clk, rst, cond, nxt)
`endif
`endif

// ===== sv/pfr_pkg.sv =====
// Shared types and constants for the primitive root test block.
package pfr_pkg;
  localparam logic [0:0] CmdPower = 1'b0;
  localparam logic [0:0] CmdTest  = 1'b1;
  localparam logic [0:0] RegModulus = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE, ST_REDUCE, ST_DIV, ST_DIV_DONE, ST_NEXT_Q,
    ST_POW_NEXT, ST_POW_MUL, ST_POW_SQR, ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    RET_POWER, RET_FACTOR, RET_LAST
  } ret_t;

  typedef enum logic [2:0] {
    DIV_MODRED, DIV_TRIAL, DIV_EXP, DIV_EXP_LAST, DIV_STRIP
  } div_use_t;
endpackage

// ===== sv/pfr_stream_if.sv =====
// Valid/ready channel carrying one payload.
interface pfr_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/pfr_mulmod.sv =====
// Bit-serial modular multiplier: one doubling and conditional add per cycle.
module pfr_mulmod #(
  parameter int unsigned W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] x,
  input  logic [W-1:0] y,
  input  logic [W-1:0] m,
  output logic         done,
  output logic [W-1:0] r
);
  localparam int unsigned CW = $clog2(W + 1);
  logic [W-1:0] acc, acc_next, ysh, xr;
  logic [CW-1:0] cnt;
  logic busy;
  logic [W:0] dbl, dsub, ad, asub;
  logic [W-1:0] t;

  // double then add, each reduced by one compare-subtract
  always_comb begin
    dbl  = {acc, 1'b0};
    dsub = dbl - {1'b0, m};
    t    = dsub[W] ? dbl[W-1:0] : dsub[W-1:0];
    ad   = {1'b0, t} + {1'b0, xr};
    asub = ad - {1'b0, m};
    acc_next = ysh[W-1] ? (asub[W] ? ad[W-1:0] : asub[W-1:0]) : t;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
        acc  <= '0;
        ysh  <= y;
        xr   <= x;
      end else if (busy) begin
        acc <= acc_next;
        ysh <= ysh << 1;
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign r = acc;
endmodule

// ===== sv/prime_field_primitive_root_test_top.sv =====
// Top level: modular power and primitive root test over a configured prime.
// Sequence: the divider first reduces the base modulo the prime, then a power runs by
// square-and-multiply, with one squaring per exponent bit and one multiply per set bit.
// The test runs trial divisors up to sqrt(p-1) through the divider plus one power per factor.
// One transaction at a time; the next is accepted from the cycle after the result handoff.
// Synchronous active-high reset: modulus returns to 3, control goes idle.
`include "prime_field_primitive_root_test_top_assert.svh"
module prime_field_primitive_root_test_top #(
  parameter int unsigned MODULUS_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [31:0] base_value,
  input  logic [31:0] exponent,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] power_result,
  output logic        is_primitive_root
);
  localparam int unsigned W = MODULUS_WIDTH;
  localparam int unsigned IW = (W > 32) ? W : 32;
  localparam int unsigned CW = $clog2(IW + 1);

  pfr_pkg::state_t state, state_next;
  pfr_pkg::ret_t ret;
  pfr_pkg::div_use_t du;
  logic [31:0] modulus;
  logic [W-1:0] m, m1, xbase, xb, pr, rest, q, rem, dvs;
  logic [IW-1:0] dvd, e;
  logic [CW-1:0] dcnt;
  logic cmd, res_root;
  logic [31:0] res_pow;
  logic mstart, mdone, msq;
  logic [W-1:0] mx, mr;
  logic [W:0] rsh, rtry;
  logic cfg_wr, quo_low, pr_one;

  assign m = W'(modulus);
  assign m1 = m - W'(1);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == pfr_pkg::RegModulus) ? modulus : '0;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign quo_low = (dvd < IW'(q));
  assign pr_one = (pr == W'(1));

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) modulus <= 32'd3;
    else if (cfg_wr && paddr[2] == pfr_pkg::RegModulus) modulus <= pwdata;
  end

  pfr_mulmod #(.W(W)) u_mul (
    .clk(clk), .rst(rst), .start(mstart), .x(mx), .y(xb), .m(m),
    .done(mdone), .r(mr));
  assign mx = msq ? xb : pr;

  // restoring divider step, one quotient bit per cycle
  always_comb begin
    rsh  = {rem, dvd[IW-1]};
    rtry = rsh - {1'b0, dvs};
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      pfr_pkg::ST_IDLE: if (in_valid) state_next = pfr_pkg::ST_REDUCE;
      pfr_pkg::ST_REDUCE: begin
        state_next = (m < W'(2)) ? pfr_pkg::ST_OUT : pfr_pkg::ST_DIV;
      end
      pfr_pkg::ST_DIV: if (dcnt == CW'(1)) state_next = pfr_pkg::ST_DIV_DONE;
      pfr_pkg::ST_DIV_DONE: begin
        case (du)
          pfr_pkg::DIV_MODRED: begin
            if (cmd == pfr_pkg::CmdPower) state_next = pfr_pkg::ST_POW_NEXT;
            else if (rem == '0) state_next = pfr_pkg::ST_OUT;
            else state_next = pfr_pkg::ST_NEXT_Q;
          end
          pfr_pkg::DIV_TRIAL: begin
            if (quo_low) state_next = (rest > W'(1)) ? pfr_pkg::ST_DIV : pfr_pkg::ST_OUT;
            else if (rem == '0) state_next = pfr_pkg::ST_DIV;
            else state_next = pfr_pkg::ST_NEXT_Q;
          end
          pfr_pkg::DIV_EXP, pfr_pkg::DIV_EXP_LAST: state_next = pfr_pkg::ST_POW_NEXT;
          pfr_pkg::DIV_STRIP: begin
            state_next = (rem == '0) ? pfr_pkg::ST_DIV : pfr_pkg::ST_NEXT_Q;
          end
          default: state_next = pfr_pkg::ST_IDLE;
        endcase
      end
      pfr_pkg::ST_NEXT_Q: state_next = pfr_pkg::ST_DIV;
      pfr_pkg::ST_POW_NEXT: begin
        if (e == '0) begin
          if (ret == pfr_pkg::RET_FACTOR && !pr_one) state_next = pfr_pkg::ST_DIV;
          else state_next = pfr_pkg::ST_OUT;
        end else if (e[0]) begin
          state_next = pfr_pkg::ST_POW_MUL;
        end else begin
          state_next = pfr_pkg::ST_POW_SQR;
        end
      end
      pfr_pkg::ST_POW_MUL: if (mdone) state_next = pfr_pkg::ST_POW_SQR;
      pfr_pkg::ST_POW_SQR: if (mdone) state_next = pfr_pkg::ST_POW_NEXT;
      pfr_pkg::ST_OUT: if (out_ready) state_next = pfr_pkg::ST_IDLE;
      default: state_next = pfr_pkg::ST_IDLE;
    endcase
  end

  // handshake and multiplier control
  always_comb begin
    in_ready = (state == pfr_pkg::ST_IDLE);
    out_valid = (state == pfr_pkg::ST_OUT);
    mstart = 1'b0;
    msq = 1'b1;
    case (state)
      pfr_pkg::ST_POW_NEXT: begin
        mstart = (e != '0);
        msq = ~e[0];
      end
      pfr_pkg::ST_POW_MUL: mstart = mdone;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= pfr_pkg::ST_IDLE;
    else state <= state_next;
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      pfr_pkg::ST_IDLE: if (in_valid) begin
        cmd <= command;
        dvd <= IW'(base_value);
        e <= IW'(exponent);
        res_pow <= '0;
        res_root <= 1'b0;
      end
      pfr_pkg::ST_REDUCE: begin
        du <= pfr_pkg::DIV_MODRED;
        dvs <= m; rem <= '0; dcnt <= CW'(IW);
      end
      pfr_pkg::ST_DIV: begin
        rem <= rtry[W] ? rsh[W-1:0] : rtry[W-1:0];
        dvd <= {dvd[IW-2:0], ~rtry[W]};
        dcnt <= dcnt - CW'(1);
      end
      pfr_pkg::ST_DIV_DONE: begin
        case (du)
          pfr_pkg::DIV_MODRED: begin
            xbase <= rem; xb <= rem; pr <= W'(1); ret <= pfr_pkg::RET_POWER;
            rest <= m1; q <= W'(2);
          end
          pfr_pkg::DIV_TRIAL: begin
            if (quo_low) begin
              // search done: only the leftover factor is still to be tried
              if (rest > W'(1)) begin
                du <= pfr_pkg::DIV_EXP_LAST;
                dvd <= IW'(m1); dvs <= rest; rem <= '0; dcnt <= CW'(IW);
              end else begin
                res_root <= 1'b1;
              end
            end else if (rem == '0) begin
              du <= pfr_pkg::DIV_EXP;
              dvd <= IW'(m1); dvs <= q; rem <= '0; dcnt <= CW'(IW);
            end else begin
              q <= q + W'(1);
            end
          end
          pfr_pkg::DIV_EXP, pfr_pkg::DIV_EXP_LAST: begin
            e <= dvd; xb <= xbase; pr <= W'(1);
            ret <= (du == pfr_pkg::DIV_EXP_LAST) ? pfr_pkg::RET_LAST : pfr_pkg::RET_FACTOR;
          end
          pfr_pkg::DIV_STRIP: begin
            // divide q out of rest until it no longer divides
            if (rem == '0) begin
              rest <= W'(dvd); rem <= '0; dcnt <= CW'(IW);
            end else begin
              q <= q + W'(1);
            end
          end
          default: ;
        endcase
      end
      pfr_pkg::ST_NEXT_Q: begin
        // rest / q gives both the loop bound test and divisibility
        du <= pfr_pkg::DIV_TRIAL;
        dvd <= IW'(rest); dvs <= q; rem <= '0; dcnt <= CW'(IW);
      end
      pfr_pkg::ST_POW_NEXT: if (e == '0) begin
        case (ret)
          pfr_pkg::RET_POWER: res_pow <= 32'(pr);
          pfr_pkg::RET_FACTOR: if (!pr_one) begin
            du <= pfr_pkg::DIV_STRIP;
            dvd <= IW'(rest); dvs <= q; rem <= '0; dcnt <= CW'(IW);
          end
          default: res_root <= !pr_one;
        endcase
      end
      pfr_pkg::ST_POW_MUL: if (mdone) pr <= mr;
      pfr_pkg::ST_POW_SQR: if (mdone) begin
        xb <= mr;
        e <= e >> 1;
      end
      default: ;
    endcase
  end

  assign power_result = res_pow;
  assign is_primitive_root = res_root;

  `PFR_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `PFR_ASSERT_IMPL(a_busy_noready, clk, rst, out_valid |-> !in_ready)
  `PFR_ASSERT_NEXT(a_cmd_clear, clk, rst, out_valid && cmd == pfr_pkg::CmdPower, !res_root)
endmodule

// ===== bench/prime_field_primitive_root_test_top_tb.sv =====
// Self-checking testbench for the prime field power and primitive root test block.
`timescale 1ns / 100ps
module prime_field_primitive_root_test_top_tb;

  typedef struct packed {
    logic [0:0]  command;
    logic [31:0] base_value;
    logic [31:0] exponent;
  } field_op_t;

  typedef struct packed {
    logic [31:0] power_result;
    logic        is_primitive_root;
  } field_res_t;

  localparam int unsigned MaxGap = 18;
  localparam int unsigned StallLimit = 4000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  pfr_stream_if #(.payload_t(field_op_t)) op_ch ();
  pfr_stream_if #(.payload_t(field_res_t)) res_ch ();

  field_res_t res_q[$];
  logic [31:0] modulus_shadow = 32'd3;
  int unsigned mismatch_cnt = 0;
  int unsigned idle_cnt = 0;
  int unsigned ready_hold = 0;
  bit idling_on = 1'b1;

  initial begin
    op_ch.valid = 1'b0;
    op_ch.payload = '0;
    res_ch.ready = 1'b0;
  end

  always #5 clk = ~clk;

  prime_field_primitive_root_test_top i_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(op_ch.valid), .in_ready(op_ch.ready),
    .command(op_ch.payload.command), .base_value(op_ch.payload.base_value),
    .exponent(op_ch.payload.exponent),
    .out_valid(res_ch.valid), .out_ready(res_ch.ready),
    .power_result(res_ch.payload.power_result),
    .is_primitive_root(res_ch.payload.is_primitive_root)
  );

  // Modular arithmetic; operands below 2^32 so products fit in 64 bits
  function automatic longint unsigned mod_pow(longint unsigned x, longint unsigned e,
                                              longint unsigned m);
    longint unsigned r;
    r = 1 % m;
    while (e != 0) begin
      if (e[0]) r = (r * x) % m;
      x = (x * x) % m;
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic bit generates_group(longint unsigned x, longint unsigned m);
    longint unsigned rest;
    longint unsigned q;
    rest = m - 1;
    if (x == 0) return 1'b0;
    // distinct prime factors of p-1 by trial division
    for (q = 2; q <= rest / q; q++) begin
      if (rest % q == 0) begin
        if (mod_pow(x, (m - 1) / q, m) == 1) return 1'b0;
        while (rest % q == 0) rest = rest / q;
      end
    end
    // large factor left over
    if (rest > 1 && mod_pow(x, (m - 1) / rest, m) == 1) return 1'b0;
    return 1'b1;
  endfunction

  function automatic field_res_t predict_field_op(field_op_t op, logic [31:0] modulus);
    field_res_t r;
    longint unsigned m;
    longint unsigned b;
    r = '0;
    m = modulus;
    if (m < 2) return r;
    b = op.base_value % m;
    if (op.command == pfr_pkg::CmdPower) r.power_result = 32'(mod_pow(b, op.exponent, m));
    else r.is_primitive_root = generates_group(b, m);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("ERROR at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    mismatch_cnt++;
  endtask

  // Register write, setup then access phase
  task automatic write_modulus(logic [31:0] value);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = {pfr_pkg::RegModulus, 2'b00}; pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    modulus_shadow = value;
  endtask

  // Wait for outstanding results, then let the block settle before a write
  task automatic drain();
    wait (res_q.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_op(logic [0:0] cmd, logic [31:0] b, logic [31:0] e);
    int unsigned gap;
    field_op_t op;
    gap = idling_on ? $urandom_range(0, MaxGap) : 0;
    if (gap > 0) begin
      op_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    op.command = cmd; op.base_value = b; op.exponent = e;
    op_ch.payload = op;
    op_ch.valid = 1'b1;
    do @(posedge clk); while (!op_ch.ready);
    res_q.push_back(predict_field_op(op, modulus_shadow));
    @(negedge clk);
    op_ch.valid = 1'b0;
  endtask

  task automatic end_stream();
    op_ch.valid = 1'b0;
  endtask

  // Result checker
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      field_res_t want;
      if (res_q.size() == 0) begin
        report_mismatch("unexpected result", res_ch.payload, 0);
      end else begin
        want = res_q.pop_front();
        if (res_ch.payload.power_result !== want.power_result)
          report_mismatch("power_result", res_ch.payload.power_result, want.power_result);
        if (res_ch.payload.is_primitive_root !== want.is_primitive_root)
          report_mismatch("is_primitive_root", res_ch.payload.is_primitive_root,
                          want.is_primitive_root);
      end
      ready_hold = idling_on ? $urandom_range(0, MaxGap) : 0;
    end
  end

  // Result side stalls
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      res_ch.ready <= 1'b0;
      ready_hold = ready_hold - 1;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // Watchdog on cycles with no transaction
  always @(posedge clk) begin
    if ((op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready)) idle_cnt = 0;
    else idle_cnt++;
    if (idle_cnt >= StallLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic test_reset_modulus();
    send_op(pfr_pkg::CmdPower, 32'd0, 32'd0);
    send_op(pfr_pkg::CmdPower, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(pfr_pkg::CmdTest, 32'd0, 32'd0);
    send_op(pfr_pkg::CmdTest, 32'd2, 32'd0);
    send_op(pfr_pkg::CmdTest, 32'd4, 32'hFFFF_FFFF);
    end_stream();
  endtask

  task automatic test_small_moduli();
    drain(); write_modulus(32'd2);
    send_op(pfr_pkg::CmdTest, 32'd1, 32'd0);
    send_op(pfr_pkg::CmdTest, 32'd2, 32'd0);
    send_op(pfr_pkg::CmdPower, 32'd3, 32'd5);
    drain(); write_modulus(32'd0);
    send_op(pfr_pkg::CmdPower, 32'd7, 32'd3);
    send_op(pfr_pkg::CmdTest, 32'd7, 32'd3);
    drain(); write_modulus(32'd1);
    send_op(pfr_pkg::CmdPower, 32'd0, 32'd0);
    send_op(pfr_pkg::CmdTest, 32'd5, 32'd0);
    drain(); write_modulus(32'd15);
    send_op(pfr_pkg::CmdTest, 32'd2, 32'd0);
    send_op(pfr_pkg::CmdPower, 32'd2, 32'd4);
    end_stream();
  endtask

  task automatic test_wide_moduli();
    drain(); write_modulus(32'hFFFF_FFFF);
    send_op(pfr_pkg::CmdPower, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_op(pfr_pkg::CmdPower, 32'hFFFF_FFFF, 32'd0);
    send_op(pfr_pkg::CmdPower, 32'd0, 32'd0);
    drain(); write_modulus(32'd4294967291);
    send_op(pfr_pkg::CmdTest, 32'd2, 32'd0);
    send_op(pfr_pkg::CmdTest, 32'd4294967291, 32'd0);
    send_op(pfr_pkg::CmdPower, 32'h8000_0000, 32'd4294967290);
    end_stream();
  endtask

  task automatic test_random_ops();
    logic [31:0] primes [10];
    logic [31:0] m;
    bit wide;
    primes = '{32'd3, 32'd5, 32'd7, 32'd11, 32'd13, 32'd97, 32'd257, 32'd65537,
               32'd1000003, 32'd4294967291};
    for (int phase = 0; phase < 8; phase++) begin
      drain();
      idling_on = (phase != 3);
      wide = 1'b0;
      case ($urandom_range(0, 3))
        0: m = $urandom_range(0, 200000);
        1: begin
          m = $urandom();
          wide = 1'b1;
        end
        default: m = primes[$urandom_range(0, 9)];
      endcase
      write_modulus(m);
      for (int n = 0; n < 10; n++) begin
        logic [0:0] cmd;
        logic [31:0] b;
        cmd = wide ? pfr_pkg::CmdPower : 1'($urandom_range(0, 1));
        b = $urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : $urandom();
        send_op(cmd, b, $urandom());
      end
      end_stream();
    end
    idling_on = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_modulus();
    test_small_moduli();
    test_wide_moduli();
    test_random_ops();
    wait (res_q.size() == 0);
    repeat (100) @(posedge clk);
    if (mismatch_cnt == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+sv
sv/pfr_pkg.sv
sv/pfr_stream_if.sv
sv/pfr_mulmod.sv
sv/prime_field_primitive_root_test_top.sv
bench/prime_field_primitive_root_test_top_tb.sv
